// ===== sv/sctt_pkg.sv =====
// ----------------------------------------------------------------------------
// sctt_pkg
// Shared types and constants of the scheduled callback timer table.
// ----------------------------------------------------------------------------
package sctt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam logic [PTR_W-1:0] PTR_NONE = PTR_W'(TABLE_DEPTH);
  localparam logic [14:0] HANDLE_MAX = 15'd32000;
  localparam logic [14:0] HANDLE_FIRST = 15'd1;

  localparam logic [2:0] CMD_SCHED = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_ALL = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  localparam logic [1:0] KIND_SCHED = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] callback;
    logic [31:0] argument;
    logic [14:0] handle;
    logic [15:0] trigger;
    logic [15:0] caller;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] handle;
    logic        found;
    logic [15:0] callback;
    logic [31:0] argument;
    logic [15:0] caller;
    logic [15:0] trigger;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_inc;
    logic sched_write;
    logic sched_link;
    logic pend_sched;
    logic pend_full;
    logic pend_cancel;
    logic cancel_found;
    logic walk_start;
    logic unlink;
    logic keep;
    logic zero_caller;
    logic fire;
    logic push_pend;
    logic push_last;
    logic clear_all;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       slot_free;
    logic       scan_last;
    logic       cur_none;
    logic       handle_match;
    logic       trig_match;
    logic       caller_match;
    logic       due;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/sctt_datapath.sv =====
// ----------------------------------------------------------------------------
// sctt_datapath
// Entry memories, list pointers, handle counter and result registers.
// ----------------------------------------------------------------------------
module sctt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            cmd,
  input  logic [31:0]           frame_now,
  input  logic [31:0]           delay_frames,
  input  logic [15:0]           callback_index,
  input  logic [31:0]           argument,
  input  logic [15:0]           trigger_obj,
  input  logic [15:0]           caller_obj,
  input  logic [14:0]           target_handle,
  input  logic [15:0]           object_handle,
  input  sctt_pkg::ctl_t        ctl,
  output sctt_pkg::stat_t       stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output sctt_pkg::result_t     out_res,
  output logic                  out_last
);

  sctt_pkg::entry_t                     mem [sctt_pkg::TABLE_DEPTH];
  logic [sctt_pkg::PTR_W-1:0]           nmem [sctt_pkg::TABLE_DEPTH];
  sctt_pkg::entry_t                     rd;
  logic [sctt_pkg::PTR_W-1:0]           nrd;
  logic [sctt_pkg::TABLE_DEPTH-1:0]     valid;
  logic [sctt_pkg::PTR_W-1:0]           head;
  logic [sctt_pkg::PTR_W-1:0]           tail;
  logic [sctt_pkg::PTR_W-1:0]           cur;
  logic [sctt_pkg::PTR_W-1:0]           prev;
  logic [sctt_pkg::IDX_W-1:0]           slot;
  logic [14:0]                          cnt;
  logic [14:0]                          cnt_next;
  logic [2:0]                           op;
  logic [31:0]                          now;
  logic [14:0]                          target;
  logic [15:0]                          obj;
  sctt_pkg::entry_t                     newent;
  sctt_pkg::result_t                    pend;
  logic                                 pend_valid;
  logic [sctt_pkg::IDX_W-1:0]           cur_idx;
  logic [sctt_pkg::IDX_W-1:0]           prev_idx;
  logic [sctt_pkg::IDX_W-1:0]           tail_idx;
  logic                                 do_unlink;

  assign cur_idx = cur[sctt_pkg::IDX_W-1:0];
  assign prev_idx = prev[sctt_pkg::IDX_W-1:0];
  assign tail_idx = tail[sctt_pkg::IDX_W-1:0];
  assign do_unlink = ctl.unlink | ctl.fire;

  always_comb begin
    cnt_next = cnt + 15'd1;
    if (cnt_next > sctt_pkg::HANDLE_MAX || cnt_next == 15'd0) begin
      cnt_next = sctt_pkg::HANDLE_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= cmd;
      now <= frame_now;
      target <= target_handle;
      obj <= object_handle;
      newent <= '{due: frame_now + delay_frames, callback: callback_index,
                  argument: argument, handle: 15'd0, trigger: trigger_obj,
                  caller: caller_obj};
    end
    if (ctl.scan_start) begin
      slot <= '0;
    end else if (ctl.scan_inc) begin
      slot <= slot + sctt_pkg::IDX_W'(1);
    end
    if (ctl.walk_start) begin
      cur <= head;
      prev <= sctt_pkg::PTR_NONE;
    end else if (do_unlink) begin
      cur <= nrd;
    end else if (ctl.keep) begin
      prev <= cur;
      cur <= nrd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[cur_idx];
    nrd <= nmem[cur_idx];
    if (ctl.sched_write) begin
      mem[slot] <= '{due: newent.due, callback: newent.callback,
                     argument: newent.argument, handle: cnt_next,
                     trigger: newent.trigger, caller: newent.caller};
    end else if (ctl.zero_caller) begin
      mem[cur_idx] <= '{due: rd.due, callback: rd.callback, argument: rd.argument,
                        handle: rd.handle, trigger: rd.trigger, caller: 16'd0};
    end
    if (ctl.sched_write) begin
      nmem[slot] <= sctt_pkg::PTR_NONE;
    end else if (ctl.sched_link && tail != sctt_pkg::PTR_NONE) begin
      nmem[tail_idx] <= {1'b0, slot};
    end else if (do_unlink && prev != sctt_pkg::PTR_NONE) begin
      nmem[prev_idx] <= nrd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      head <= sctt_pkg::PTR_NONE;
      tail <= sctt_pkg::PTR_NONE;
      cnt <= sctt_pkg::HANDLE_FIRST;
    end else begin
      if (ctl.clear_all) begin
        valid <= '0;
        head <= sctt_pkg::PTR_NONE;
        tail <= sctt_pkg::PTR_NONE;
      end else if (ctl.sched_write) begin
        valid[slot] <= 1'b1;
        cnt <= cnt_next;
      end else if (ctl.sched_link) begin
        if (tail == sctt_pkg::PTR_NONE) begin
          head <= {1'b0, slot};
        end
        tail <= {1'b0, slot};
      end else if (do_unlink) begin
        valid[cur_idx] <= 1'b0;
        if (prev == sctt_pkg::PTR_NONE) begin
          head <= nrd;
        end
        if (tail == cur) begin
          tail <= prev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.fire || ctl.pend_sched || ctl.pend_full || ctl.pend_cancel) begin
        pend_valid <= 1'b1;
      end else if (ctl.push_pend) begin
        pend_valid <= 1'b0;
      end
      if (ctl.push_pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      pend <= '{kind: sctt_pkg::KIND_FIRE, handle: rd.handle, found: 1'b0,
                callback: rd.callback, argument: rd.argument, caller: rd.caller,
                trigger: rd.trigger};
    end else if (ctl.pend_sched) begin
      pend <= '{kind: sctt_pkg::KIND_SCHED, handle: cnt, default: '0};
    end else if (ctl.pend_full) begin
      pend <= '{kind: sctt_pkg::KIND_SCHED, default: '0};
    end else if (ctl.pend_cancel) begin
      pend <= '{kind: sctt_pkg::KIND_CANCEL, found: ctl.cancel_found, default: '0};
    end
    if (ctl.push_pend) begin
      out_res <= pend;
      out_last <= ctl.push_last;
    end
  end

  assign stat.op = op;
  assign stat.slot_free = !valid[slot];
  assign stat.scan_last = (slot == sctt_pkg::IDX_W'(sctt_pkg::TABLE_DEPTH - 1));
  assign stat.cur_none = (cur == sctt_pkg::PTR_NONE);
  assign stat.handle_match = (rd.handle == target);
  assign stat.trig_match = (rd.trigger == obj);
  assign stat.caller_match = (rd.caller == obj);
  assign stat.due = (rd.due <= now);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 15'd0 && cnt <= sctt_pkg::HANDLE_MAX)
    else $error("handle counter out of range");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (head == sctt_pkg::PTR_NONE) == (tail == sctt_pkg::PTR_NONE))
    else $error("list head and tail disagree on emptiness");
  a_unlink_valid: assert property (@(posedge clk) disable iff (rst)
    do_unlink |-> valid[cur_idx])
    else $error("unlinking a free slot");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ctl.push_pend |-> pend_valid && (!out_valid || out_ready))
    else $error("result pushed over a waiting result");
`endif

endmodule

// ===== sv/sctt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sctt_ctrl
// Command sequencer of the scheduled callback timer table.
// ----------------------------------------------------------------------------
module sctt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        cmd,
  input  sctt_pkg::stat_t   stat,
  output sctt_pkg::ctl_t    ctl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_SWRITE = 7'b0000100,
    S_SLINK  = 7'b0001000,
    S_WRD    = 7'b0010000,
    S_WEX    = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          if (cmd == sctt_pkg::CMD_SCHED) begin
            ctl.scan_start = 1'b1;
            state_next = S_SCAN;
          end else if (cmd == sctt_pkg::CMD_CANCEL || cmd == sctt_pkg::CMD_CLEAR ||
                       cmd == sctt_pkg::CMD_TICK) begin
            ctl.walk_start = 1'b1;
            state_next = S_WRD;
          end else if (cmd == sctt_pkg::CMD_ALL) begin
            ctl.clear_all = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.slot_free) begin
          state_next = S_SWRITE;
        end else if (stat.scan_last) begin
          ctl.pend_full = 1'b1;
          state_next = S_FLUSH;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_SWRITE: begin
        ctl.sched_write = 1'b1;
        state_next = S_SLINK;
      end
      S_SLINK: begin
        ctl.sched_link = 1'b1;
        ctl.pend_sched = 1'b1;
        state_next = S_FLUSH;
      end
      S_WRD: begin
        if (!stat.cur_none) begin
          state_next = S_WEX;
        end else if (stat.op == sctt_pkg::CMD_CANCEL) begin
          ctl.pend_cancel = 1'b1;
          state_next = S_FLUSH;
        end else if (stat.pend_valid) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WEX: begin
        if (stat.op == sctt_pkg::CMD_CANCEL) begin
          if (stat.handle_match) begin
            ctl.unlink = 1'b1;
            ctl.pend_cancel = 1'b1;
            ctl.cancel_found = 1'b1;
            state_next = S_FLUSH;
          end else begin
            ctl.keep = 1'b1;
            state_next = S_WRD;
          end
        end else if (stat.op == sctt_pkg::CMD_CLEAR) begin
          if (stat.trig_match) begin
            ctl.unlink = 1'b1;
          end else begin
            ctl.keep = 1'b1;
            ctl.zero_caller = stat.caller_match;
          end
          state_next = S_WRD;
        end else if (stat.due) begin
          if (!stat.pend_valid || stat.out_free) begin
            ctl.fire = 1'b1;
            ctl.push_pend = stat.pend_valid;
            state_next = S_WRD;
          end
        end else begin
          ctl.keep = 1'b1;
          state_next = S_WRD;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          ctl.push_pend = 1'b1;
          ctl.push_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/scheduled_callback_timer_table.sv =====
// ----------------------------------------------------------------------------
// scheduled_callback_timer_table
// Table of pending timed callbacks kept as a linked list in insertion order.
// ----------------------------------------------------------------------------
// The input channel takes one command per transfer: schedule, cancel, cancel
// all, clear object or tick. Results leave on the output channel, each with
// last set on the final result of its command.
// Schedule scans the valid bits one slot a cycle for the lowest free slot,
// then stores and links the entry, or reports that the table is full.
// Cancel, clear object and tick walk the list, reading an entry and then
// examining it (the entry memories have a registered read port).
// Cancel all clears the table without a walk and returns no result.
// One command is in work at a time; a new transfer is taken when the
// sequencer is idle, even while the last result still waits in the output
// register.
// Reset empties the table and sets the handle counter to 1; no clearing pass
// is needed. When the receiver stalls, the block holds its result and waits
// at the point where the next result would be produced.
// ----------------------------------------------------------------------------
module scheduled_callback_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] frame_now,
  input  logic [31:0] delay_frames,
  input  logic [15:0] callback_index,
  input  logic [31:0] argument,
  input  logic [15:0] trigger_obj,
  input  logic [15:0] caller_obj,
  input  logic [14:0] target_handle,
  input  logic [15:0] object_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [14:0] timer_handle,
  output logic        found,
  output logic [15:0] fired_callback,
  output logic [31:0] fired_argument,
  output logic [15:0] fired_caller,
  output logic [15:0] fired_trigger,
  output logic        last
);

  sctt_pkg::ctl_t    ctl;
  sctt_pkg::stat_t   stat;
  sctt_pkg::result_t res;

  sctt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  sctt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .frame_now      (frame_now),
    .delay_frames   (delay_frames),
    .callback_index (callback_index),
    .argument       (argument),
    .trigger_obj    (trigger_obj),
    .caller_obj     (caller_obj),
    .target_handle  (target_handle),
    .object_handle  (object_handle),
    .ctl            (ctl),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_res        (res),
    .out_last       (last)
  );

  assign kind = res.kind;
  assign timer_handle = res.handle;
  assign found = res.found;
  assign fired_callback = res.callback;
  assign fired_argument = res.argument;
  assign fired_caller = res.caller;
  assign fired_trigger = res.trigger;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the scheduled callback timer table.
// ----------------------------------------------------------------------------
// A behavioural copy of the table predicts every result of each accepted
// command. An always block compares each transfer on the output channel with
// the oldest prediction. Directed tests cover field extremes, every command,
// a full table and the handle edge cases. A long random phase follows, built
// from all commands and unused codes, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] now;
    logic [31:0] delay;
    logic [15:0] cb;
    logic [31:0] arg;
    logic [15:0] trig;
    logic [15:0] caller;
    logic [14:0] target;
    logic [15:0] obj;
  } cmd_item_t;

  typedef struct {
    sctt_pkg::result_t r;
    logic              last;
  } timer_result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [2:0] cmd = 0;
  logic [31:0] frame_now = 0, delay_frames = 0, argument = 0;
  logic [15:0] callback_index = 0, trigger_obj = 0, caller_obj = 0, object_handle = 0;
  logic [14:0] target_handle = 0;
  logic in_ready, out_valid, found, last;
  logic [1:0] kind;
  logic [14:0] timer_handle;
  logic [15:0] fired_callback, fired_caller, fired_trigger;
  logic [31:0] fired_argument;

  scheduled_callback_timer_table dut (.*);

  // Behavioural copy of the table.
  sctt_pkg::entry_t slot_mem [sctt_pkg::TABLE_DEPTH];
  int     slot_next [sctt_pkg::TABLE_DEPTH];
  bit     slot_live [sctt_pkg::TABLE_DEPTH];
  int     head_ptr, tail_ptr;
  logic [14:0] handle_ctr;

  timer_result_t pending_results[$];
  int errors = 0, n_items = 0, n_results = 0, n_fired = 0;
  bit no_idle = 0;
  int ready_hold = 0;
  logic [31:0] frame_base = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_result(logic [1:0] k, logic [14:0] h, logic f,
                             sctt_pkg::entry_t e);
    timer_result_t t;
    t.r = '0;
    t.r.kind = k;
    t.r.handle = h;
    t.r.found = f;
    if (k == sctt_pkg::KIND_FIRE) begin
      t.r.callback = e.callback;
      t.r.argument = e.argument;
      t.r.caller = e.caller;
      t.r.trigger = e.trigger;
    end
    t.last = 0;
    pending_results.push_back(t);
  endtask

  task automatic drop_slot(int prev, int idx);
    if (prev == sctt_pkg::TABLE_DEPTH) head_ptr = slot_next[idx];
    else slot_next[prev] = slot_next[idx];
    if (tail_ptr == idx) tail_ptr = prev;
    slot_live[idx] = 0;
  endtask

  task automatic predict_table(cmd_item_t it);
    int queued, free_slot, prev, cur, nxt, n;
    sctt_pkg::entry_t e;
    bit hit;
    queued = pending_results.size();
    n = 0;
    e = '0;
    case (it.cmd)
      sctt_pkg::CMD_SCHED: begin
        free_slot = sctt_pkg::TABLE_DEPTH;
        for (int i = sctt_pkg::TABLE_DEPTH - 1; i >= 0; i--)
          if (!slot_live[i]) free_slot = i;
        if (free_slot == sctt_pkg::TABLE_DEPTH) begin
          push_result(sctt_pkg::KIND_SCHED, '0, 0, e);
        end else begin
          handle_ctr = handle_ctr + 15'd1;
          if (handle_ctr > sctt_pkg::HANDLE_MAX || handle_ctr == 0)
            handle_ctr = sctt_pkg::HANDLE_FIRST;
          e.due = it.now + it.delay;
          e.callback = it.cb;
          e.argument = it.arg;
          e.trigger = it.trig;
          e.caller = it.caller;
          e.handle = handle_ctr;
          slot_mem[free_slot] = e;
          slot_next[free_slot] = sctt_pkg::TABLE_DEPTH;
          slot_live[free_slot] = 1;
          if (tail_ptr == sctt_pkg::TABLE_DEPTH) head_ptr = free_slot;
          else slot_next[tail_ptr] = free_slot;
          tail_ptr = free_slot;
          push_result(sctt_pkg::KIND_SCHED, handle_ctr, 0, e);
        end
      end
      sctt_pkg::CMD_CANCEL: begin
        prev = sctt_pkg::TABLE_DEPTH;
        cur = head_ptr;
        hit = 0;
        while (cur < sctt_pkg::TABLE_DEPTH && !hit) begin
          if (slot_mem[cur].handle == it.target) begin
            drop_slot(prev, cur);
            hit = 1;
          end else begin
            prev = cur;
            cur = slot_next[cur];
          end
        end
        push_result(sctt_pkg::KIND_CANCEL, '0, hit, e);
      end
      sctt_pkg::CMD_ALL: begin
        for (int i = 0; i < sctt_pkg::TABLE_DEPTH; i++) slot_live[i] = 0;
        head_ptr = sctt_pkg::TABLE_DEPTH;
        tail_ptr = sctt_pkg::TABLE_DEPTH;
      end
      sctt_pkg::CMD_CLEAR: begin
        prev = sctt_pkg::TABLE_DEPTH;
        cur = head_ptr;
        while (cur < sctt_pkg::TABLE_DEPTH) begin
          nxt = slot_next[cur];
          if (slot_mem[cur].trigger == it.obj) drop_slot(prev, cur);
          else begin
            if (slot_mem[cur].caller == it.obj) slot_mem[cur].caller = '0;
            prev = cur;
          end
          cur = nxt;
        end
      end
      sctt_pkg::CMD_TICK: begin
        prev = sctt_pkg::TABLE_DEPTH;
        cur = head_ptr;
        while (cur < sctt_pkg::TABLE_DEPTH) begin
          nxt = slot_next[cur];
          if (slot_mem[cur].due <= it.now && n < 64) begin
            push_result(sctt_pkg::KIND_FIRE, slot_mem[cur].handle, 0, slot_mem[cur]);
            n++;
            n_fired++;
            drop_slot(prev, cur);
          end else prev = cur;
          cur = nxt;
        end
      end
      default: ;
    endcase
    if (pending_results.size() > queued)
      pending_results[pending_results.size() - 1].last = 1;
  endtask

  task automatic send_item(cmd_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd <= it.cmd;
    frame_now <= it.now;
    delay_frames <= it.delay;
    callback_index <= it.cb;
    argument <= it.arg;
    trigger_obj <= it.trig;
    caller_obj <= it.caller;
    target_handle <= it.target;
    object_handle <= it.obj;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    predict_table(it);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  function automatic cmd_item_t make_item(logic [2:0] c);
    cmd_item_t it;
    it.cmd = c;
    it.now = $urandom;
    it.delay = $urandom;
    it.cb = $urandom;
    it.arg = $urandom;
    it.trig = $urandom;
    it.caller = $urandom;
    it.target = $urandom;
    it.obj = $urandom;
    return it;
  endfunction

  // Output side: checks each transfer and draws the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d handle %0d", $time, kind, timer_handle);
          errors++;
        end else begin
          timer_result_t t;
          t = pending_results.pop_front();
          if (t.r.kind !== kind || t.r.handle !== timer_handle || t.r.found !== found ||
              t.r.callback !== fired_callback || t.r.argument !== fired_argument ||
              t.r.caller !== fired_caller || t.r.trigger !== fired_trigger ||
              t.last !== last) begin
            $display({"%0t: expected kind %0d handle %0d found %0d cb %h arg %h",
                      " caller %h trig %h last %0d"},
                     $time, t.r.kind, t.r.handle, t.r.found, t.r.callback, t.r.argument,
                     t.r.caller, t.r.trigger, t.last);
            $display({"%0t: actual   kind %0d handle %0d found %0d cb %h arg %h",
                      " caller %h trig %h last %0d"},
                     $time, kind, timer_handle, found, fired_callback, fired_argument,
                     fired_caller, fired_trigger, last);
            errors++;
          end
        end
        ready_hold = no_idle ? 0 : $urandom_range(0, 7);
        if (ready_hold > 0) out_ready <= 0;
      end else if (ready_hold > 0) begin
        ready_hold--;
        if (ready_hold == 0) out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  task automatic test_directed();
    cmd_item_t it;
    it = make_item(sctt_pkg::CMD_SCHED);
    it.now = '0; it.delay = '0; it.cb = '0; it.arg = '0; it.trig = '0; it.caller = '0;
    send_item(it);
    it = make_item(sctt_pkg::CMD_SCHED);
    it.now = '1; it.delay = '1; it.cb = '1; it.arg = '1; it.trig = '1; it.caller = '1;
    send_item(it);
    it = make_item(sctt_pkg::CMD_SCHED);
    it.now = 32'hFFFF_FFF0; it.delay = 32'h20; it.trig = 16'd5; it.caller = 16'd5;
    send_item(it);
    it = make_item(sctt_pkg::CMD_SCHED);
    it.now = 32'd100; it.delay = 32'd10; it.trig = 16'd7; it.caller = 16'd5;
    send_item(it);
    it = make_item(sctt_pkg::CMD_TICK); it.now = 32'd0; send_item(it);
    it = make_item(sctt_pkg::CMD_TICK); it.now = 32'd109; send_item(it);
    it = make_item(sctt_pkg::CMD_CLEAR); it.obj = 16'd5; send_item(it);
    it = make_item(sctt_pkg::CMD_CLEAR); it.obj = 16'd0; send_item(it);
    it = make_item(sctt_pkg::CMD_CANCEL); it.target = 15'd0; send_item(it);
    it = make_item(sctt_pkg::CMD_CANCEL); it.target = 15'h7FFF; send_item(it);
    it = make_item(sctt_pkg::CMD_CANCEL); it.target = 15'd32001; send_item(it);
    it = make_item(sctt_pkg::CMD_CANCEL); it.target = handle_ctr; send_item(it);
    it = make_item(sctt_pkg::CMD_CANCEL); it.target = handle_ctr; send_item(it);
    for (int c = 5; c < 8; c++) begin
      it = make_item(3'(c)); send_item(it);
    end
    it = make_item(sctt_pkg::CMD_TICK); it.now = '1; send_item(it);
    it = make_item(sctt_pkg::CMD_SCHED); send_item(it);
    it = make_item(sctt_pkg::CMD_ALL); send_item(it);
    it = make_item(sctt_pkg::CMD_TICK); it.now = '1; send_item(it);
    wait_drained();
  endtask

  task automatic test_table_full();
    cmd_item_t it;
    no_idle = 1;
    for (int i = 0; i < sctt_pkg::TABLE_DEPTH + 2; i++) begin
      it = make_item(sctt_pkg::CMD_SCHED);
      it.now = 32'd0; it.delay = 32'(i);
      send_item(it);
    end
    no_idle = 0;
    it = make_item(sctt_pkg::CMD_TICK); it.now = 32'd30; send_item(it);
    it = make_item(sctt_pkg::CMD_SCHED); it.now = 32'd0; it.delay = 32'd0; send_item(it);
    it = make_item(sctt_pkg::CMD_TICK); it.now = '1; send_item(it);
    wait_drained();
  endtask

  task automatic test_random(int count);
    cmd_item_t it;
    int pick, live_cnt;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 50) no_idle = ~no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 45) it = make_item(sctt_pkg::CMD_SCHED);
      else if (pick < 70) it = make_item(sctt_pkg::CMD_TICK);
      else if (pick < 84) it = make_item(sctt_pkg::CMD_CANCEL);
      else if (pick < 94) it = make_item(sctt_pkg::CMD_CLEAR);
      else if (pick < 97) it = make_item(sctt_pkg::CMD_ALL);
      else it = make_item(3'($urandom_range(5, 7)));
      if (it.cmd == sctt_pkg::CMD_TICK) frame_base += $urandom_range(0, 25);
      if ($urandom_range(0, 19) != 0) begin
        it.now = frame_base;
        if ($urandom_range(0, 9) != 0) it.delay = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) it.trig = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) it.caller = $urandom_range(0, 3);
        if ($urandom_range(0, 2) != 0) it.obj = $urandom_range(0, 3);
        live_cnt = 0;
        for (int i = 0; i < sctt_pkg::TABLE_DEPTH; i++) if (slot_live[i]) live_cnt++;
        if (live_cnt > 0 && $urandom_range(0, 3) != 0) begin
          live_cnt = $urandom_range(1, live_cnt);
          for (int i = 0; i < sctt_pkg::TABLE_DEPTH; i++)
            if (slot_live[i]) begin
              live_cnt--;
              if (live_cnt == 0) it.target = slot_mem[i].handle;
            end
        end
      end
      send_item(it);
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < sctt_pkg::TABLE_DEPTH; i++) slot_live[i] = 0;
    head_ptr = sctt_pkg::TABLE_DEPTH;
    tail_ptr = sctt_pkg::TABLE_DEPTH;
    handle_ctr = sctt_pkg::HANDLE_FIRST;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(360);
    $display("Run covered %0d commands: %0d results checked, %0d fired timers,",
             n_items, n_results, n_fired);
    $display("including a full table, cancel misses and object clearing.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/sctt_pkg.sv
sv/sctt_datapath.sv
sv/sctt_ctrl.sv
sv/scheduled_callback_timer_table.sv
tb/sv/tb.sv
